>>> hdl/tclp_pkg.sv
`default_nettype none

package tclp_pkg;

    localparam int BUTTON_COUNT = 16;
    localparam int PROX_COUNT   = 8;

    localparam logic [15:0] BTN_MASK  = 16'((17'd1 << BUTTON_COUNT) - 17'd1);
    localparam logic [7:0]  PROX_MASK = 8'((9'd1 << PROX_COUNT) - 9'd1);
    localparam logic [3:0]  BTN_LAST  = 4'(BUTTON_COUNT - 1);
    localparam logic [3:0]  PROX_LAST = 4'(PROX_COUNT - 1);

    localparam logic [15:0] TOUCH_WINDOW_RST = 16'd250;
    localparam logic [15:0] LONG_TOUCH_RST   = 16'd1250;
    localparam logic [7:0]  COUNT_MAX        = 8'd255;

    localparam logic CFG_TOUCH_WINDOW = 1'b0;
    localparam logic CFG_LONG_TOUCH   = 1'b1;

    localparam logic OP_STATUS = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    typedef enum logic [1:0] {
        EV_BUTTON = 2'd0,
        EV_PROX   = 2'd1,
        EV_DONE   = 2'd2,
        EV_LONG   = 2'd3
    } t_evt_kind;

    typedef struct packed {
        t_evt_kind   kind;
        logic [3:0]  index;
        logic        level;
        logic [7:0]  count;
        logic        last_flag;
    } t_evt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BTN,
        ST_PROX,
        ST_POLL,
        ST_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_BTN,
        MD_PROX,
        MD_POLL,
        MD_FLUSH
    } t_dp_mode;

    typedef struct packed {
        t_dp_mode    mode;
        logic        load;
        logic [3:0]  idx;
    } t_dp_cmd;

    typedef struct packed {
        logic step_done;
        logic flush_done;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/tclp_in_if.sv
`default_nettype none

interface tclp_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] button_bits;
    logic [7:0]  proximity_bits;
    logic [31:0] now_ms;

    modport source (output valid, output opcode, output button_bits,
                    output proximity_bits, output now_ms, input ready);
    modport sink   (input valid, input opcode, input button_bits,
                    input proximity_bits, input now_ms, output ready);
endinterface

`default_nettype wire

>>> hdl/tclp_out_if.sv
`default_nettype none

interface tclp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [3:0] sensor_index;
    logic       level;
    logic [7:0] click_count;
    logic       last_flag;

    modport source (output valid, output event_kind, output sensor_index,
                    output level, output click_count, output last_flag, input ready);
    modport sink   (input valid, input event_kind, input sensor_index,
                    input level, input click_count, input last_flag, output ready);
endinterface

`default_nettype wire

>>> hdl/tclp_ctrl.sv
`default_nettype none

module tclp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_opcode,
    input  wire tclp_pkg::t_dp_sts i_sts,
    output tclp_pkg::t_dp_cmd      o_cmd,
    output logic                   o_in_ready
);

    tclp_pkg::t_state r_state, n_state;
    logic [3:0]       r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tclp_pkg::ST_IDLE;
            r_idx   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_in_ready = 1'b0;
        o_cmd.mode = tclp_pkg::MD_IDLE;
        o_cmd.load = 1'b0;
        o_cmd.idx  = r_idx;
        case (r_state)
            tclp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = 4'd0;
                    n_state    = (i_opcode == tclp_pkg::OP_POLL) ? tclp_pkg::ST_POLL
                                                                 : tclp_pkg::ST_BTN;
                end
            end
            tclp_pkg::ST_BTN: begin
                o_cmd.mode = tclp_pkg::MD_BTN;
                if (i_sts.step_done) begin
                    if (r_idx == tclp_pkg::BTN_LAST) begin
                        n_idx   = 4'd0;
                        n_state = tclp_pkg::ST_PROX;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            tclp_pkg::ST_PROX: begin
                o_cmd.mode = tclp_pkg::MD_PROX;
                if (i_sts.step_done) begin
                    if (r_idx == tclp_pkg::PROX_LAST) begin
                        n_state = tclp_pkg::ST_FLUSH;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            tclp_pkg::ST_POLL: begin
                o_cmd.mode = tclp_pkg::MD_POLL;
                if (i_sts.step_done) begin
                    if (r_idx == tclp_pkg::BTN_LAST) begin
                        n_state = tclp_pkg::ST_FLUSH;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            tclp_pkg::ST_FLUSH: begin
                o_cmd.mode = tclp_pkg::MD_FLUSH;
                if (i_sts.flush_done) begin
                    n_state = tclp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tclp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/tclp_dp.sv
`default_nettype none

module tclp_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data,
    input  wire tclp_pkg::t_dp_cmd i_cmd,
    input  wire logic [15:0]       i_button_bits,
    input  wire logic [7:0]        i_proximity_bits,
    input  wire logic [31:0]       i_now_ms,
    input  wire logic              i_out_ready,
    output tclp_pkg::t_dp_sts      o_sts,
    output logic                   o_out_valid,
    output tclp_pkg::t_evt         o_res
);

    // configuration
    logic [15:0] r_win;
    logic [15:0] r_long;

    // latched item
    logic [31:0] r_now;
    logic [15:0] r_cur_b;
    logic [7:0]  r_cur_p;

    // sensor state
    logic [15:0] r_prev_b;
    logic [7:0]  r_prev_p;
    logic [31:0] r_press [16];
    logic [31:0] r_rel   [16];
    logic [15:0] r_rel_v;
    logic [7:0]  r_cnt   [16];
    logic [15:0] r_pend;

    // held result and output register
    tclp_pkg::t_evt r_held;
    logic           r_held_v;
    tclp_pkg::t_evt r_out;
    logic           r_out_v;

    logic [3:0]     w_bi;
    logic [2:0]     w_pi;
    logic [31:0]    w_d_press;
    logic [31:0]    w_d_rel;
    logic           w_near;
    logic           w_long_hit;
    logic           w_done_hit;
    logic           w_ev;
    tclp_pkg::t_evt w_evt;
    logic           w_stepping;
    logic           w_out_free;
    logic           w_step;
    logic           w_flush;

    assign w_bi      = i_cmd.idx;
    assign w_pi      = i_cmd.idx[2:0];
    assign w_d_press = r_now - r_press[w_bi];
    assign w_d_rel   = r_now - r_rel[w_bi];
    assign w_near     = r_rel_v[w_bi] && (w_d_rel <= {16'd0, r_win});
    assign w_long_hit = w_d_press >= {16'd0, r_long};
    assign w_done_hit = r_rel_v[w_bi] && (w_d_rel >= {16'd0, r_win});

    always_comb begin
        w_ev            = 1'b0;
        w_stepping      = 1'b0;
        w_evt.kind      = tclp_pkg::EV_BUTTON;
        w_evt.index     = i_cmd.idx;
        w_evt.level     = 1'b0;
        w_evt.count     = 8'd0;
        w_evt.last_flag = 1'b0;
        case (i_cmd.mode)
            tclp_pkg::MD_BTN: begin
                w_stepping  = 1'b1;
                w_ev        = r_prev_b[w_bi] ^ r_cur_b[w_bi];
                w_evt.level = r_cur_b[w_bi];
            end
            tclp_pkg::MD_PROX: begin
                w_stepping  = 1'b1;
                w_ev        = r_prev_p[w_pi] ^ r_cur_p[w_pi];
                w_evt.kind  = tclp_pkg::EV_PROX;
                w_evt.level = r_cur_p[w_pi];
            end
            tclp_pkg::MD_POLL: begin
                w_stepping = 1'b1;
                w_ev       = r_pend[w_bi] && (w_long_hit || w_done_hit);
                // long touch wins and clears the button, so no click-done follows
                if (w_long_hit) begin
                    w_evt.kind  = tclp_pkg::EV_LONG;
                    w_evt.count = 8'd1;
                end else begin
                    w_evt.kind  = tclp_pkg::EV_DONE;
                    w_evt.count = r_cnt[w_bi];
                end
            end
            default: begin
                w_ev = 1'b0;
            end
        endcase
    end

    assign w_out_free = !r_out_v || i_out_ready;
    // a found event needs room: it pushes the held one into the output register
    assign w_step  = w_stepping && !(w_ev && r_held_v && !w_out_free);
    assign w_flush = (i_cmd.mode == tclp_pkg::MD_FLUSH) && (!r_held_v || w_out_free);

    assign o_sts.step_done  = w_step;
    assign o_sts.flush_done = w_flush;
    assign o_out_valid      = r_out_v;
    assign o_res            = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= tclp_pkg::TOUCH_WINDOW_RST;
            r_long   <= tclp_pkg::LONG_TOUCH_RST;
            r_prev_b <= 16'd0;
            r_prev_p <= 8'd0;
            r_rel_v  <= 16'd0;
            r_pend   <= 16'd0;
            for (int k = 0; k < 16; k++) begin
                r_cnt[k] <= 8'd0;
            end
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tclp_pkg::CFG_TOUCH_WINDOW: r_win  <= i_cfg_data;
                    tclp_pkg::CFG_LONG_TOUCH:   r_long <= i_cfg_data;
                    default: begin
                        r_win <= r_win;
                    end
                endcase
            end

            if (w_step) begin
                case (i_cmd.mode)
                    tclp_pkg::MD_BTN: begin
                        r_prev_b[w_bi] <= r_cur_b[w_bi];
                        if (w_ev) begin
                            if (r_cur_b[w_bi]) begin
                                if (w_near) begin
                                    if (r_cnt[w_bi] != tclp_pkg::COUNT_MAX) begin
                                        r_cnt[w_bi] <= r_cnt[w_bi] + 8'd1;
                                    end
                                    r_rel_v[w_bi] <= 1'b0;
                                end else begin
                                    r_cnt[w_bi] <= 8'd1;
                                end
                                r_pend[w_bi] <= 1'b1;
                            end else if (r_cnt[w_bi] != 8'd0) begin
                                r_rel_v[w_bi] <= 1'b1;
                                r_pend[w_bi]  <= 1'b1;
                            end
                        end
                    end
                    tclp_pkg::MD_PROX: begin
                        r_prev_p[w_pi] <= r_cur_p[w_pi];
                    end
                    tclp_pkg::MD_POLL: begin
                        if (w_ev) begin
                            r_rel_v[w_bi] <= 1'b0;
                            r_cnt[w_bi]   <= 8'd0;
                            r_pend[w_bi]  <= 1'b0;
                        end
                    end
                    default: begin
                        r_pend <= r_pend;
                    end
                endcase
            end

            if (w_step && w_ev) begin
                r_held_v <= 1'b1;
            end else if (w_flush) begin
                r_held_v <= 1'b0;
            end

            if ((w_step && w_ev && r_held_v) || (w_flush && r_held_v)) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now   <= i_now_ms;
            r_cur_b <= i_button_bits & tclp_pkg::BTN_MASK;
            r_cur_p <= i_proximity_bits & tclp_pkg::PROX_MASK;
        end
        if (w_step && (i_cmd.mode == tclp_pkg::MD_BTN) && w_ev) begin
            if (r_cur_b[w_bi]) begin
                r_press[w_bi] <= r_now;
            end else if (r_cnt[w_bi] != 8'd0) begin
                r_rel[w_bi] <= r_now;
            end
        end
        if (w_step && w_ev) begin
            r_held <= w_evt;
        end
        if (w_step && w_ev && r_held_v) begin
            r_out <= '{kind: r_held.kind, index: r_held.index, level: r_held.level,
                       count: r_held.count, last_flag: 1'b0};
        end else if (w_flush && r_held_v) begin
            r_out <= '{kind: r_held.kind, index: r_held.index, level: r_held.level,
                       count: r_held.count, last_flag: 1'b1};
        end
    end

endmodule

`default_nettype wire

>>> hdl/touch_click_long_press_classifier_top.sv
// touch click / long-press classifier
// input channel i_item: one item per transfer; opcode status carries the button
// and proximity levels, opcode poll asks for finished touches; both carry now_ms.
// output channel o_evt: one transfer per event, last_flag marks the final event
// of an item; an item that raises no event gives no transfer.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 touch window, 1 long touch time); the user must write only while the
// block is idle, the block itself does not enforce it.
// timing: the sequencer scans one sensor bit per cycle unless the output stalls
// it; a status item scans 16 button bits, 8 proximity bits and a flush before
// the next ready, a poll item 16 button bits and a flush.
// an event moves into the output register when the next event is found, or at
// the flush that ends the item; the last event sits in the output register
// while the next item is already taken. when the receiver holds ready low, the
// scan stalls at a found event once held event and output register are full.
// reset: synchronous, active low; clears seen levels, flags and click counts, sets
// the touch window to 250 ms and the long touch time to 1250 ms.
`default_nettype none

module touch_click_long_press_classifier_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    tclp_in_if.sink          i_item,
    tclp_out_if.source       o_evt
);

    tclp_pkg::t_dp_cmd w_cmd;
    tclp_pkg::t_dp_sts w_sts;
    tclp_pkg::t_evt    w_res;
    logic              w_in_ready;
    logic              w_out_valid;

    tclp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_opcode   (i_item.opcode),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    tclp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (w_cmd),
        .i_button_bits    (i_item.button_bits),
        .i_proximity_bits (i_item.proximity_bits),
        .i_now_ms         (i_item.now_ms),
        .i_out_ready      (o_evt.ready),
        .o_sts            (w_sts),
        .o_out_valid      (w_out_valid),
        .o_res            (w_res)
    );

    assign i_item.ready       = w_in_ready;
    assign o_evt.valid        = w_out_valid;
    assign o_evt.event_kind   = w_res.kind;
    assign o_evt.sensor_index = w_res.index;
    assign o_evt.level        = w_res.level;
    assign o_evt.click_count  = w_res.count;
    assign o_evt.last_flag    = w_res.last_flag;

endmodule

`default_nettype wire

>>> hdl/tclp_checker.sv
`default_nettype none

module tclp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_kind,
    input wire logic [3:0] i_index,
    input wire logic       i_level,
    input wire logic [7:0] i_count,
    input wire logic       i_last
);

    // protocol: a waiting event stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("event dropped while stalled");

    // protocol: a waiting event keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_kind) && $stable(i_index) && $stable(i_level) &&
            $stable(i_count) && $stable(i_last))
        else $error("stalled event changed");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while busy");

    // while idle only the final event of the previous item can wait
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_in_ready |-> i_last)
        else $error("non-final event pending while idle");

    a_long_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == tclp_pkg::EV_LONG) |-> (i_count == 8'd1) && !i_level)
        else $error("long touch fields wrong");

endmodule

bind touch_click_long_press_classifier_top tclp_checker u_tclp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_kind      (o_evt.event_kind),
    .i_index     (o_evt.sensor_index),
    .i_level     (o_evt.level),
    .i_count     (o_evt.click_count),
    .i_last      (o_evt.last_flag)
);

`default_nettype wire

>>> dv/touch_click_long_press_classifier_top_test.sv
`timescale 1ns / 100ps

module touch_click_long_press_classifier_top_test;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_data;

    tclp_in_if  item_if();
    tclp_out_if evt_if();

    touch_click_long_press_classifier_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_evt      (evt_if)
    );

    // classifier state as predicted
    logic [15:0] win_ms;
    logic [15:0] long_ms;
    logic [15:0] seen_btn;
    logic [7:0]  seen_prox;
    logic [31:0] press_time [tclp_pkg::BUTTON_COUNT];
    logic [31:0] rel_time   [tclp_pkg::BUTTON_COUNT];
    logic        rel_ok     [tclp_pkg::BUTTON_COUNT];
    logic [7:0]  clicks     [tclp_pkg::BUTTON_COUNT];
    logic        pending    [tclp_pkg::BUTTON_COUNT];

    tclp_pkg::t_evt due_events[$];
    logic [31:0]    clock_ms;
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    int unsigned    hold_request = 0;
    int unsigned    fail_count = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void forget_button(int i);
        press_time[i] = 32'd0;
        rel_time[i]   = 32'd0;
        rel_ok[i]     = 1'b0;
        clicks[i]     = 8'd0;
        pending[i]    = 1'b0;
    endfunction

    function automatic void reset_classifier();
        win_ms    = tclp_pkg::TOUCH_WINDOW_RST;
        long_ms   = tclp_pkg::LONG_TOUCH_RST;
        seen_btn  = 16'd0;
        seen_prox = 8'd0;
        for (int i = 0; i < tclp_pkg::BUTTON_COUNT; i++) forget_button(i);
    endfunction

    function automatic tclp_pkg::t_evt evt_of(tclp_pkg::t_evt_kind kind, int idx,
                                              logic level, logic [7:0] count);
        tclp_pkg::t_evt e;
        e.kind      = kind;
        e.index     = 4'(idx);
        e.level     = level;
        e.count     = count;
        e.last_flag = 1'b0;
        return e;
    endfunction

    function automatic void classify_item(logic op, logic [15:0] btn, logic [7:0] prox,
                                          logic [31:0] now);
        tclp_pkg::t_evt found[$];
        logic [15:0]    cur_b;
        logic [7:0]     cur_p;
        logic [31:0]    dt;
        cur_b = btn & tclp_pkg::BTN_MASK;
        cur_p = prox & tclp_pkg::PROX_MASK;
        if (op == tclp_pkg::OP_STATUS) begin
            for (int i = 0; i < tclp_pkg::BUTTON_COUNT; i++) begin
                if (seen_btn[i] != cur_b[i]) begin
                    found.push_back(evt_of(tclp_pkg::EV_BUTTON, i, cur_b[i], 8'd0));
                    if (cur_b[i]) begin
                        dt = now - rel_time[i];
                        if (rel_ok[i] && dt <= {16'd0, win_ms}) begin
                            if (clicks[i] != tclp_pkg::COUNT_MAX) clicks[i] = clicks[i] + 8'd1;
                            rel_ok[i]   = 1'b0;
                            rel_time[i] = 32'd0;
                        end else begin
                            clicks[i] = 8'd1;
                        end
                        press_time[i] = now;
                        pending[i]    = 1'b1;
                    end else if (clicks[i] != 8'd0) begin
                        // release only counts while a click sequence is open
                        rel_time[i] = now;
                        rel_ok[i]   = 1'b1;
                        pending[i]  = 1'b1;
                    end
                end
            end
            seen_btn = cur_b;
            for (int i = 0; i < tclp_pkg::PROX_COUNT; i++) begin
                if (seen_prox[i] != cur_p[i]) begin
                    found.push_back(evt_of(tclp_pkg::EV_PROX, i, cur_p[i], 8'd0));
                end
            end
            seen_prox = cur_p;
        end else begin
            for (int i = 0; i < tclp_pkg::BUTTON_COUNT; i++) begin
                if (pending[i]) begin
                    dt = now - press_time[i];
                    if (dt >= {16'd0, long_ms}) begin
                        found.push_back(evt_of(tclp_pkg::EV_LONG, i, 1'b0, 8'd1));
                        forget_button(i);
                    end
                    dt = now - rel_time[i];
                    if (rel_ok[i] && dt >= {16'd0, win_ms}) begin
                        found.push_back(evt_of(tclp_pkg::EV_DONE, i, 1'b0, clicks[i]));
                        forget_button(i);
                    end
                end
            end
        end
        if (found.size() != 0) found[found.size() - 1].last_flag = 1'b1;
        foreach (found[k]) due_events.push_back(found[k]);
    endfunction

    function automatic void flag_error(string what);
        fail_count++;
        if (fail_count <= 10) $display("%s", what);
    endfunction

    // result checker
    initial begin : evt_check
        tclp_pkg::t_evt want;
        forever begin
            @(posedge clk);
            if (rst_n && evt_if.valid && evt_if.ready) begin
                if (due_events.size() == 0) begin
                    flag_error($sformatf("unexpected event kind %0d idx %0d at %0t",
                                         evt_if.event_kind, evt_if.sensor_index, $realtime));
                end else begin
                    want = due_events.pop_front();
                    if (evt_if.event_kind !== want.kind || evt_if.sensor_index !== want.index ||
                        evt_if.level !== want.level || evt_if.click_count !== want.count ||
                        evt_if.last_flag !== want.last_flag) begin
                        flag_error($sformatf({"event mismatch at %0t: ",
                            "exp kind %0d idx %0d lvl %0d cnt %0d last %0d, ",
                            "got kind %0d idx %0d lvl %0d cnt %0d last %0d"},
                            $realtime, want.kind, want.index, want.level, want.count,
                            want.last_flag, evt_if.event_kind, evt_if.sensor_index,
                            evt_if.level, evt_if.click_count, evt_if.last_flag));
                    end
                end
            end
        end
    end

    // event receiver
    initial begin : evt_ready_drive
        int unsigned hold;
        evt_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                hold = hold_request;
                hold_request = 0;
                evt_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            evt_if.ready <= !(rx_idle_on && ($urandom_range(99) < 28));
        end
    end

    // valid stays high from one transfer to the next unless a gap is taken
    task automatic send_item(input logic op, input logic [15:0] btn, input logic [7:0] prox,
                             input logic [31:0] now);
        if (tx_idle_on && $urandom_range(99) < 28) begin
            item_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 28);
        end
        item_if.valid          <= 1'b1;
        item_if.opcode         <= op;
        item_if.button_bits    <= btn;
        item_if.proximity_bits <= prox;
        item_if.now_ms         <= now;
        do @(posedge clk); while (!item_if.ready);
        classify_item(op, btn, prox, now);
    endtask

    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (due_events.size() != 0) @(posedge clk);
        // a poll with no events may still be scanning
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tclp_pkg::CFG_TOUCH_WINDOW) win_ms = value;
        else long_ms = value;
    endtask

    task automatic test_directed();
        logic [31:0] t;
        t = 32'd1000;
        // all bits up, all down, then click completion right at the window edge
        send_item(tclp_pkg::OP_STATUS, 16'hFFFF, 8'hFF, t);
        send_item(tclp_pkg::OP_STATUS, 16'h0000, 8'h00, t + 10);
        send_item(tclp_pkg::OP_POLL, 16'h0000, 8'h00, t + 10 + win_ms - 1);
        send_item(tclp_pkg::OP_POLL, 16'hFFFF, 8'hFF, t + 10 + win_ms);
        // alternating patterns, every bit flips at once
        send_item(tclp_pkg::OP_STATUS, 16'hA5A5, 8'h5A, t + 300);
        send_item(tclp_pkg::OP_STATUS, 16'h5A5A, 8'hA5, t + 300);
        send_item(tclp_pkg::OP_STATUS, 16'h0000, 8'h00, t + 301);
        // no change, no events; then a late poll that reports long touches
        send_item(tclp_pkg::OP_STATUS, 16'h0000, 8'h00, t + 301);
        send_item(tclp_pkg::OP_POLL, 16'h0000, 8'h00, t + 2000);
        // double click on button 2
        t = 32'd10000;
        send_item(tclp_pkg::OP_STATUS, 16'h0004, 8'h00, t);
        send_item(tclp_pkg::OP_STATUS, 16'h0000, 8'h00, t + 40);
        send_item(tclp_pkg::OP_STATUS, 16'h0004, 8'h00, t + 40 + win_ms);
        send_item(tclp_pkg::OP_STATUS, 16'h0000, 8'h00, t + 300);
        send_item(tclp_pkg::OP_POLL, 16'h0000, 8'h00, t + 300 + win_ms);
        // long touch held on button 15, then release with the sequence cleared
        t = 32'd20000;
        send_item(tclp_pkg::OP_STATUS, 16'h8000, 8'h01, t);
        send_item(tclp_pkg::OP_POLL, 16'h0000, 8'h00, t + long_ms - 1);
        send_item(tclp_pkg::OP_POLL, 16'h0000, 8'h00, t + long_ms);
        send_item(tclp_pkg::OP_STATUS, 16'h0000, 8'h00, t + 1300);
        send_item(tclp_pkg::OP_POLL, 16'h0000, 8'h00, t + 5000);
        // time wraps between the first press and its release
        send_item(tclp_pkg::OP_STATUS, 16'h0001, 8'h80, 32'hFFFF_FF00);
        send_item(tclp_pkg::OP_STATUS, 16'h0000, 8'h00, 32'h0000_0010);
        send_item(tclp_pkg::OP_STATUS, 16'h0001, 8'h00, 32'h0000_0020);
        send_item(tclp_pkg::OP_STATUS, 16'h0000, 8'h00, 32'h0000_0030);
        send_item(tclp_pkg::OP_POLL, 16'h0000, 8'h00, 32'h0000_0030 + win_ms);
        clock_ms = 32'h0001_0000;
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_request = 400;
        repeat (12) begin
            clock_ms += 5;
            send_item(tclp_pkg::OP_STATUS, ~seen_btn, ~seen_prox, clock_ms);
        end
        clock_ms += long_ms;
        send_item(tclp_pkg::OP_POLL, 16'h0000, 8'h00, clock_ms);
        wait_idle();
    endtask

    // often near a threshold so both sides of each compare get hit
    function automatic logic [31:0] pick_gap_ms();
        case ($urandom_range(6))
            0:       return 32'($urandom_range(3));
            1:       return {16'd0, win_ms} + 32'($urandom_range(2)) - 32'd1;
            2:       return {16'd0, long_ms} + 32'($urandom_range(2)) - 32'd1;
            3:       return 32'($urandom_range(win_ms));
            4:       return 32'($urandom_range(long_ms));
            5:       return 32'($urandom_range(40, 400));
            default: return $urandom;
        endcase
    endfunction

    task automatic run_touch_traffic(int unsigned n_items);
        logic [15:0] btn;
        logic [7:0]  prox;
        int unsigned roll;
        int          k;
        repeat (n_items) begin
            roll = $urandom_range(99);
            btn  = seen_btn;
            prox = seen_prox;
            clock_ms += pick_gap_ms();
            if (roll < 60) begin
                k = $urandom_range(15);
                btn[k] = ~btn[k];
                if ($urandom_range(3) == 0) begin
                    k = $urandom_range(15);
                    btn[k] = ~btn[k];
                end
                if ($urandom_range(3) == 0) begin
                    k = $urandom_range(7);
                    prox[k] = ~prox[k];
                end
                send_item(tclp_pkg::OP_STATUS, btn, prox, clock_ms);
            end else if (roll < 88) begin
                send_item(tclp_pkg::OP_POLL, 16'($urandom), 8'($urandom), clock_ms);
            end else if (roll < 95) begin
                send_item(tclp_pkg::OP_STATUS, 16'($urandom), 8'($urandom), clock_ms);
            end else begin
                send_item(roll[0] ? tclp_pkg::OP_POLL : tclp_pkg::OP_STATUS,
                          16'($urandom), 8'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_random_settings();
        logic [15:0] w;
        logic [15:0] l;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin w = 16'd0;      l = 16'hFFFF;    end
                1: begin w = 16'hFFFF;   l = 16'd0;       end
                2: begin w = 16'd250;    l = 16'd1250;    end
                3: begin w = 16'hFFFF;   l = 16'hFFFF;    end
                4: begin w = 16'd0;      l = 16'd0;       end
                5: begin w = 16'($urandom_range(1, 600)); l = 16'($urandom_range(300, 3000)); end
                default: begin w = 16'($urandom); l = 16'($urandom); end
            endcase
            write_cfg(tclp_pkg::CFG_TOUCH_WINDOW, w);
            write_cfg(tclp_pkg::CFG_LONG_TOUCH, l);
            // one stretch with both sides running flat out
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            clock_ms = $urandom;
            run_touch_traffic(55);
            wait_idle();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= tclp_pkg::CFG_TOUCH_WINDOW;
        cfg_data               <= 16'd0;
        item_if.valid          <= 1'b0;
        item_if.opcode         <= tclp_pkg::OP_STATUS;
        item_if.button_bits    <= 16'd0;
        item_if.proximity_bits <= 8'd0;
        item_if.now_ms         <= 32'd0;
        reset_classifier();
        clock_ms = 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_settings();

        wait_idle();
        if (fail_count == 0 && due_events.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/tclp_pkg.sv
hdl/tclp_in_if.sv
hdl/tclp_out_if.sv
hdl/tclp_ctrl.sv
hdl/tclp_dp.sv
hdl/touch_click_long_press_classifier_top.sv
hdl/tclp_checker.sv
dv/touch_click_long_press_classifier_top_test.sv
